/* sv/plcu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcu_pkg
// Shared types and constants of the particle lifetime/color update pipeline.
// ----------------------------------------------------------------------------
package plcu_pkg;

  localparam int NUM_CH     = 4;
  localparam int IN_BITS    = 248;
  localparam int OUT_BITS   = 160;

  // Input item layout (tdata bit offsets)
  localparam int IN_LIFE_LO  = 0;
  localparam int IN_LEVEL_LO = 32;
  localparam int IN_RATE_LO  = 96;
  localparam int IN_SIZE_LO  = 180;
  localparam int IN_SRATE_LO = 212;

  // Result item layout (tdata bit offsets)
  localparam int OUT_LIFE_LO  = 0;
  localparam int OUT_LEVEL_LO = 32;
  localparam int OUT_BYTE_LO  = 96;
  localparam int OUT_SIZE_LO  = 128;

  localparam logic [15:0] LEVEL_MAX = 16'hFF00;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_FRAME_STEP   = 1'b0;
  localparam logic REG_AGING_FROZEN = 1'b1;

  // After lifetime update
  typedef struct packed {
    logic                      killed;
    logic [31:0]               new_life;
    logic [NUM_CH-1:0][15:0]   level;
    logic [NUM_CH-1:0][20:0]   rate;
    logic [31:0]               size;
    logic [31:0]               size_rate;
    logic [15:0]               step;
  } s1_t;

  // After multiply and floor shift
  typedef struct packed {
    logic                      killed;
    logic [31:0]               new_life;
    logic [NUM_CH-1:0][15:0]   level;
    logic [NUM_CH-1:0][21:0]   delta;
    logic [31:0]               size;
    logic [32:0]               size_delta;
  } s2_t;

endpackage
`default_nettype wire

/* sv/plcu_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcu_front
// Stage 1: unpack the input item and age the lifetime with saturation.
// ----------------------------------------------------------------------------
module plcu_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [plcu_pkg::IN_BITS-1:0]  in_data,
  input  wire logic [15:0]                   frame_step,
  input  wire logic                          aging_frozen,
  output logic                               valid_r,
  output plcu_pkg::s1_t                      s1_r
);

  plcu_pkg::s1_t     s1_nxt;
  logic signed [32:0] diff;
  logic [15:0]        age;

  always_comb begin
    age  = aging_frozen ? 16'd0 : frame_step;
    diff = $signed({in_data[plcu_pkg::IN_LIFE_LO+31], in_data[plcu_pkg::IN_LIFE_LO +: 32]})
         - $signed({17'd0, age});
    s1_nxt.killed = diff[32];
    // clamp underflow at the most negative value
    if (diff[32] && !diff[31]) begin
      s1_nxt.new_life = 32'h8000_0000;
    end else begin
      s1_nxt.new_life = diff[31:0];
    end
    for (int c = 0; c < plcu_pkg::NUM_CH; c++) begin
      s1_nxt.level[c] = in_data[plcu_pkg::IN_LEVEL_LO + 16*c +: 16];
      s1_nxt.rate[c]  = in_data[plcu_pkg::IN_RATE_LO + 21*c +: 21];
    end
    s1_nxt.size      = in_data[plcu_pkg::IN_SIZE_LO +: 32];
    s1_nxt.size_rate = in_data[plcu_pkg::IN_SRATE_LO +: 32];
    s1_nxt.step      = frame_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/plcu_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcu_mul
// Stage 2: rate times frame step for four channels and the size, floor >> 16.
// ----------------------------------------------------------------------------
module plcu_mul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  plcu_pkg::s1_t      s1,
  output logic               valid_r,
  output plcu_pkg::s2_t      s2_r
);

  plcu_pkg::s2_t                            s2_nxt;
  logic signed [plcu_pkg::NUM_CH-1:0][37:0] prod;
  logic signed [48:0]                       size_prod;

  always_comb begin
    for (int c = 0; c < plcu_pkg::NUM_CH; c++) begin
      prod[c]         = $signed(s1.rate[c]) * $signed({1'b0, s1.step});
      s2_nxt.delta[c] = prod[c][37:16];
    end
    size_prod         = $signed(s1.size_rate) * $signed({1'b0, s1.step});
    s2_nxt.size_delta = size_prod[48:16];
    s2_nxt.killed     = s1.killed;
    s2_nxt.new_life   = s1.new_life;
    s2_nxt.level      = s1.level;
    s2_nxt.size       = s1.size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/plcu_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plcu_back
// Stage 3: add deltas, clamp levels, saturate size, mask killed particles.
// ----------------------------------------------------------------------------
module plcu_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  plcu_pkg::s2_t                       s2,
  output logic                                valid_r,
  output logic [plcu_pkg::OUT_BITS-1:0]       data_r,
  output logic                                killed_r
);

  logic [plcu_pkg::OUT_BITS-1:0] data_nxt;
  logic signed [22:0]            sum;
  logic [15:0]                   lvl;
  logic signed [33:0]            size_sum;
  logic [31:0]                   nsize;

  always_comb begin
    data_nxt = '0;
    data_nxt[plcu_pkg::OUT_LIFE_LO +: 32] = s2.new_life;
    for (int c = 0; c < plcu_pkg::NUM_CH; c++) begin
      sum = $signed({7'd0, s2.level[c]}) + $signed({s2.delta[c][21], s2.delta[c]});
      if (sum < 0) begin
        lvl = 16'd0;
      end else if (sum > $signed({7'd0, plcu_pkg::LEVEL_MAX})) begin
        lvl = plcu_pkg::LEVEL_MAX;
      end else begin
        lvl = sum[15:0];
      end
      if (s2.killed) begin
        lvl = 16'd0;
      end
      data_nxt[plcu_pkg::OUT_LEVEL_LO + 16*c +: 16] = lvl;
      data_nxt[plcu_pkg::OUT_BYTE_LO + 8*c +: 8]    = lvl[15:8];
    end
    size_sum = $signed({{2{s2.size[31]}}, s2.size})
             + $signed({s2.size_delta[32], s2.size_delta});
    if (!size_sum[33] && (size_sum[32] || size_sum[31])) begin
      nsize = 32'h7FFF_FFFF;
    end else if (size_sum[33] && !(size_sum[32] && size_sum[31])) begin
      nsize = 32'h8000_0000;
    end else begin
      nsize = size_sum[31:0];
    end
    if (s2.killed) begin
      nsize = 32'd0;
    end
    data_nxt[plcu_pkg::OUT_SIZE_LO +: 32] = nsize;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r   <= data_nxt;
      killed_r <= s2.killed;
    end
  end

endmodule
`default_nettype wire

/* sv/particle_lifetime_color_update_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// particle_lifetime_color_update_unit
// Per-particle frame update: lifetime aging, color level and size advance.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one particle per item (lifetime, four levels, four rates, size,
//           size rate). out_* : one result per item, killed flag on tuser.
//   cfg_* : frame_step at address 0, aging_frozen at address 4; write only
//           while no item is in flight.
// Latency: three register stages (age, multiply, clamp); out_tvalid rises once
//   the item has passed the age, multiply and clamp registers. Throughput: one
//   item per cycle unless out_tready stalls the output; the five multipliers all
//   sit in the middle stage and are fully pipelined.
// Reset: rst_n clears the stage valid bits and both registers to 0.
// Stall: while out_tready is low the output holds; upstream stages keep
//   filling empty slots, and in_tready drops once all three stages hold items.
// ----------------------------------------------------------------------------
module particle_lifetime_color_update_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // life_left[31:0], level_ch0..3[16 each], rate_ch0..3[21 each],
  // particle_size[31:0], size_rate[31:0], zero pad[3:0]
  input  wire logic [247:0]  in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // new_life[31:0], new_level_ch0..3[16 each], byte_ch0..3[8 each], new_size[31:0]
  output logic [159:0]       out_tdata,
  // killed
  output logic               out_tuser,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [2:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [15:0]   frame_step_r;
  logic          aging_frozen_r;
  logic          cfg_wr;

  logic          v1, v2, v3;
  logic          en1, en2, en3;
  plcu_pkg::s1_t s1;
  plcu_pkg::s2_t s2;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_step_r   <= 16'd0;
      aging_frozen_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        plcu_pkg::REG_FRAME_STEP:   frame_step_r   <= cfg_pwdata[15:0];
        plcu_pkg::REG_AGING_FROZEN: aging_frozen_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      plcu_pkg::REG_FRAME_STEP:   cfg_prdata = {16'd0, frame_step_r};
      plcu_pkg::REG_AGING_FROZEN: cfg_prdata = {31'd0, aging_frozen_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // advance a stage when it is empty or its successor advances
  assign en3       = !v3 | out_tready;
  assign en2       = !v2 | en3;
  assign en1       = !v1 | en2;
  assign in_tready = en1;

  plcu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en1),
    .in_valid     (in_tvalid),
    .in_data      (in_tdata),
    .frame_step   (frame_step_r),
    .aging_frozen (aging_frozen_r),
    .valid_r      (v1),
    .s1_r         (s1)
  );

  plcu_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en2),
    .in_valid (v1),
    .s1       (s1),
    .valid_r  (v2),
    .s2_r     (s2)
  );

  plcu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en3),
    .in_valid (v2),
    .s2       (s2),
    .valid_r  (v3),
    .data_r   (out_tdata),
    .killed_r (out_tuser)
  );

  assign out_tvalid = v3;

endmodule
`default_nettype wire

/* verif/tb_particle_lifetime_color_update_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_particle_lifetime_color_update_unit
// Self-checking bench for the particle frame update pipeline. Particles go in
// over the input stream and are predicted in fixed point at acceptance. Every
// result is compared field by field against the oldest prediction. Frame step
// and aging freeze are reprogrammed between phases, and sender gaps and result
// back-pressure change from phase to phase.
// ----------------------------------------------------------------------------

typedef struct {
  logic [31:0]      life;
  logic [3:0][15:0] level;
  logic [3:0][20:0] rate;
  logic [31:0]      size;
  logic [31:0]      size_rate;
} particle_t;

typedef struct {
  logic             killed;
  logic [31:0]      life;
  logic [3:0][15:0] level;
  logic [3:0][7:0]  color_byte;
  logic [31:0]      size;
} particle_update_t;

class particle_scoreboard;
  logic [15:0]      frame_step;
  logic             aging_frozen;
  particle_update_t expected_updates[$];
  int               mismatches;
  int               updates_checked;
  int               killed_seen;

  function new();
    frame_step      = '0;
    aging_frozen    = 1'b0;
    mismatches      = 0;
    updates_checked = 0;
    killed_seen     = 0;
  endfunction

  function longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function particle_update_t predict_update(particle_t p);
    particle_update_t u;
    longint           step;
    longint           life_next;
    longint           lvl;
    longint           size_next;
    step      = longint'({48'd0, frame_step});
    life_next = clamp_s32(longint'(signed'(p.life)) - (aging_frozen ? 64'sd0 : step));
    u.killed  = life_next < 0;
    u.life    = life_next[31:0];
    for (int c = 0; c < 4; c++) begin
      // products floor toward minus infinity
      lvl = longint'({48'd0, p.level[c]}) + ((longint'(signed'(p.rate[c])) * step) >>> 16);
      if (lvl < 0) lvl = 0;
      if (lvl > longint'({48'd0, plcu_pkg::LEVEL_MAX})) lvl = longint'({48'd0, plcu_pkg::LEVEL_MAX});
      if (u.killed) lvl = 0;
      u.level[c]      = lvl[15:0];
      u.color_byte[c] = lvl[15:8];
    end
    size_next = clamp_s32(longint'(signed'(p.size)) +
                          ((longint'(signed'(p.size_rate)) * step) >>> 16));
    u.size = u.killed ? 32'd0 : size_next[31:0];
    return u;
  endfunction

  function void note_particle(particle_t p);
    expected_updates.push_back(predict_update(p));
  endfunction

  function void compare_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", field, exp_v, act_v);
      mismatches++;
    end
  endfunction

  function void check_update(logic killed, logic [159:0] data);
    particle_update_t u;
    if (expected_updates.size() == 0) begin
      $error("result item with no particle outstanding: killed=%0b data=0x%040h", killed, data);
      mismatches++;
      return;
    end
    u = expected_updates.pop_front();
    updates_checked++;
    if (u.killed) killed_seen++;
    compare_field("killed", {31'd0, u.killed}, {31'd0, killed});
    compare_field("new_life", u.life, data[plcu_pkg::OUT_LIFE_LO +: 32]);
    for (int c = 0; c < 4; c++) begin
      compare_field($sformatf("new_level_ch%0d", c), {16'd0, u.level[c]},
                    {16'd0, data[plcu_pkg::OUT_LEVEL_LO + 16*c +: 16]});
      compare_field($sformatf("byte_ch%0d", c), {24'd0, u.color_byte[c]},
                    {24'd0, data[plcu_pkg::OUT_BYTE_LO + 8*c +: 8]});
    end
    compare_field("new_size", u.size, data[plcu_pkg::OUT_SIZE_LO +: 32]);
  endfunction
endclass

module tb_particle_lifetime_color_update_unit;

  localparam int          CYCLE_LIMIT      = 400000;
  localparam logic [2:0]  ADDR_FRAME_STEP  = {plcu_pkg::REG_FRAME_STEP, 2'b00};
  localparam logic [2:0]  ADDR_AGING_FROZEN = {plcu_pkg::REG_AGING_FROZEN, 2'b00};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // life_left, level_ch0..3, rate_ch0..3, particle_size, size_rate, zero pad
  logic [247:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // new_life, new_level_ch0..3, byte_ch0..3, new_size
  logic [159:0] out_tdata;
  // killed
  logic         out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  particle_scoreboard sb = new();
  int                 stall_max = 0;
  int                 ready_run = 0;
  int                 cycle_count = 0;
  int                 settings_run = 0;

  particle_lifetime_color_update_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Result back-pressure: alternate ready and stall runs of random length.
  always @(posedge clk) begin
    if (stall_max == 0) begin
      out_tready <= 1'b1;
    end else if (ready_run == 0) begin
      out_tready <= ~out_tready;
      ready_run  = out_tready ? $urandom_range(1, stall_max) : $urandom_range(1, 8);
    end else begin
      ready_run = ready_run - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_update(out_tuser, out_tdata);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] extreme_value(int w);
    logic [31:0] mask;
    mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return mask;
      2:       return 32'd1 << (w - 1);
      default: return mask >> 1;
    endcase
  endfunction

  function automatic particle_t make_particle(logic [31:0] life, logic [15:0] level,
                                              logic [20:0] rate, logic [31:0] size,
                                              logic [31:0] size_rate);
    particle_t p;
    p.life = life;
    for (int c = 0; c < 4; c++) begin
      p.level[c] = level;
      p.rate[c]  = rate;
    end
    p.size      = size;
    p.size_rate = size_rate;
    return p;
  endfunction

  function automatic particle_t random_particle();
    particle_t p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: p.life = $urandom_range(32'h0001_0000, 32'h7FFF_FFFF);
      5, 6, 7:       p.life = $urandom_range(0, 32'h0001_FFFF);  // near one step
      8:             p.life = $urandom();
      default:       p.life = extreme_value(32);
    endcase
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(0, 7))
        0:       p.level[c] = 16'h0000;
        1:       p.level[c] = plcu_pkg::LEVEL_MAX;
        2:       p.level[c] = 16'($urandom_range(16'hFF01, 16'hFFFF));
        default: p.level[c] = 16'($urandom());
      endcase
      p.rate[c] = ($urandom_range(0, 5) == 0) ? 21'(extreme_value(21)) : 21'($urandom());
    end
    p.size      = ($urandom_range(0, 5) == 0) ? extreme_value(32) : $urandom();
    p.size_rate = ($urandom_range(0, 5) == 0) ? extreme_value(32) : $urandom();
    return p;
  endfunction

  // Hold the item until accepted; valid stays high on return.
  task automatic drive_particle(particle_t p);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, p.size_rate, p.size, p.rate, p.level, p.life};
    do @(posedge clk); while (!in_tready);
    sb.note_particle(p);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.expected_updates.size() != 0);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame_config(logic [15:0] step, logic frozen);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_write(ADDR_FRAME_STEP, {16'd0, step});
    cfg_write(ADDR_AGING_FROZEN, {31'd0, frozen});
    sb.frame_step   = step;
    sb.aging_frozen = frozen;
    settings_run++;
  endtask

  // Valid may stay high on return; the caller drops it.
  task automatic send_random(int count, int gap_max);
    int burst_left;
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < count; i++) begin
      drive_particle(random_particle());
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if (gap_max > 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, gap_max)) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    logic [15:0] phase_step [8];
    logic        phase_frozen [8];
    int          phase_stall [8];
    int          phase_gap [8];

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full step, live aging
    set_frame_config(16'hFFFF, 1'b0);
    drive_particle(make_particle(32'h7FFF_FFFF, 16'h0000, 21'h0F_FFFF, 32'h0, 32'h7FFF_FFFF));
    drive_particle(make_particle(32'h7FFF_FFFF, plcu_pkg::LEVEL_MAX, 21'h0F_FFFF, 32'h1,
                                 32'h1));
    drive_particle(make_particle(32'h7FFF_FFFF, 16'hFFFF, 21'h00_0000, 32'h0, 32'h0));
    drive_particle(make_particle(32'h7FFF_FFFF, 16'h0000, 21'h10_0000, 32'h0, 32'hFFFF_FFFF));
    drive_particle(make_particle(32'h0100_0000, 16'h8000, 21'h1F_FFFF, 32'h0, 32'hFFFF_FFFF));
    drive_particle(make_particle(32'h0000_FFFF, 16'h1234, 21'h00_0100, 32'h10, 32'h10000));
    drive_particle(make_particle(32'h0000_FFFE, 16'h1234, 21'h00_0100, 32'h10, 32'h10000));
    drive_particle(make_particle(32'h8000_0000, plcu_pkg::LEVEL_MAX, 21'h0F_FFFF,
                                 32'h7FFF_FFFF, 32'h1));
    drive_particle(make_particle(32'h7FFF_FFFF, 16'h4000, 21'h00_0080, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF));
    drive_particle(make_particle(32'h7FFF_FFFF, 16'h4000, 21'h1F_FF80, 32'h8000_0000,
                                 32'h8000_0000));
    drive_particle(make_particle(32'h0002_0000, 16'hFF00, 21'h10_0000, 32'h0, 32'h8000_0000));
    drive_particle(make_particle(32'hFFFF_FFFF, 16'hFFFF, 21'h0F_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF));
    // frozen aging: lifetime holds, colors and size still advance
    set_frame_config(16'hFFFF, 1'b1);
    drive_particle(make_particle(32'h0000_0000, 16'h0100, 21'h00_1000, 32'h100, 32'h20000));
    drive_particle(make_particle(32'hFFFF_FFFF, 16'h0100, 21'h00_1000, 32'h100, 32'h20000));
    drive_particle(make_particle(32'h8000_0000, 16'h0100, 21'h00_1000, 32'h100, 32'h20000));
    drive_particle(make_particle(32'h7FFF_FFFF, 16'hFFFF, 21'h10_0000, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF));
    // zero step: nothing moves except clamping of out-of-range levels and masking of killed particles
    set_frame_config(16'h0000, 1'b0);
    drive_particle(make_particle(32'h0000_0000, 16'hFFFF, 21'h0F_FFFF, 32'h8000_0000,
                                 32'h8000_0000));
    drive_particle(make_particle(32'hFFFF_FFFF, 16'hFF00, 21'h10_0000, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF));

    phase_step   = '{16'h8000, 16'hFFFF, 16'h0001, 16'h0000, 16'h0444, 16'h0000, 16'hFFFF,
                     16'h0000};
    phase_frozen = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    phase_stall  = '{0, 4, 12, 2, 0, 8, 1, 6};
    phase_gap    = '{0, 3, 0, 6, 2, 1, 0, 4};
    phase_step[5] = 16'($urandom());
    phase_step[7] = 16'($urandom());

    for (int ph = 0; ph < 8; ph++) begin
      set_frame_config(phase_step[ph], phase_frozen[ph]);
      stall_max = phase_stall[ph];
      if (ph == 2) begin
        // let the pipeline empty mid-stream before resuming
        send_random(110, phase_gap[ph]);
        in_tvalid <= 1'b0;
        wait_drained();
        send_random(110, phase_gap[ph]);
      end else begin
        send_random(215, phase_gap[ph]);
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    stall_max = 0;
    repeat (10) @(posedge clk);
    $display("Covered %0d particle updates (%0d killed) over %0d step/aging settings.",
             sb.updates_checked, sb.killed_seen, settings_run);
    $display("Sender bursts, result stalls and a mid-stream drain were mixed by phase.");
    if (sb.mismatches == 0 && sb.expected_updates.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
